// File: src/efbd_pkg.sv
// Shared types and constants for the escaped frame byte decoder.
`timescale 1ns / 1ps

package efbd_pkg;

    localparam logic [7:0] CODE_ESC       = 8'h7D;
    localparam logic [7:0] CODE_DELIM     = 8'h7E;
    localparam logic [7:0] ESC_OFFSET     = 8'h20;
    localparam logic [7:0] BUF_SIZE_RESET = 8'd254;

    localparam int PADDR_W = 1;
    localparam int PDATA_W = 32;

    localparam logic [PADDR_W-1:0] REG_BUFFER_SIZE = '0;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PAYLOAD = 2'd1,
        MODE_ESCAPE  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_DONE    = 2'd1,
        EV_OVERRUN = 2'd2
    } event_t;

    typedef struct packed {
        event_t     event_res;
        logic [7:0] frame_length;
        logic       store_valid;
        logic [7:0] store_index;
        logic [7:0] store_data;
    } result_t;

endpackage

// File: src/efbd_ifs.sv
// Valid/ready channel interfaces for received bytes and decode results.
`timescale 1ns / 1ps

interface efbd_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface efbd_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_res;
    logic [7:0] frame_length;
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_data;

    modport source (output valid, output event_res, output frame_length,
                    output store_valid, output store_index, output store_data,
                    input ready);
    modport sink (input valid, input event_res, input frame_length,
                  input store_valid, input store_index, input store_data,
                  output ready);
endinterface

// File: src/efbd_core.sv
// Destuffing state machine: mode and byte count, one byte per step.
`timescale 1ns / 1ps

module efbd_core
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  logic [7:0]        rx_byte,
    input  logic [7:0]        buffer_size,
    output efbd_pkg::result_t result
);

    efbd_pkg::mode_t mode_reg;
    efbd_pkg::mode_t mode_next;
    logic [7:0]      count_reg;
    logic [7:0]      count_next;
    logic [7:0]      data_byte;
    logic            room;

    assign data_byte = (mode_reg == efbd_pkg::MODE_ESCAPE) ?
                       8'(rx_byte + efbd_pkg::ESC_OFFSET) : rx_byte;
    assign room      = count_reg < buffer_size;

    // next state
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        if (rx_byte == efbd_pkg::CODE_DELIM)
        begin
            mode_next  = efbd_pkg::MODE_PAYLOAD;
            count_next = '0;
        end
        else if (rx_byte == efbd_pkg::CODE_ESC)
        begin
            mode_next = efbd_pkg::MODE_ESCAPE;
        end
        else if (mode_reg != efbd_pkg::MODE_IDLE)
        begin
            if (room)
            begin
                mode_next  = efbd_pkg::MODE_PAYLOAD;
                count_next = 8'(count_reg + 8'd1);
            end
            else
            begin
                mode_next = efbd_pkg::MODE_IDLE;
            end
        end
    end

    // outputs
    always_comb
    begin
        result = '{efbd_pkg::EV_NONE, 8'd0, 1'b0, 8'd0, 8'd0};
        if (rx_byte == efbd_pkg::CODE_DELIM)
        begin
            if (count_reg != 8'd0)
            begin
                result.event_res    = efbd_pkg::EV_DONE;
                result.frame_length = count_reg;
            end
        end
        else if (rx_byte != efbd_pkg::CODE_ESC && mode_reg != efbd_pkg::MODE_IDLE)
        begin
            if (room)
            begin
                result.store_valid = 1'b1;
                result.store_index = count_reg;
                result.store_data  = data_byte;
            end
            else
            begin
                result.event_res    = efbd_pkg::EV_OVERRUN;
                result.frame_length = 8'(buffer_size + 8'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= efbd_pkg::MODE_IDLE;
            count_reg <= '0;
        end
        else if (step_en)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        result.store_valid |-> result.store_index < buffer_size)
        else $error("store index beyond buffer size");

    a_store_counts: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && result.store_valid |=> count_reg == 8'($past(count_reg) + 8'd1))
        else $error("count did not advance on store");

    a_overrun_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && result.event_res == efbd_pkg::EV_OVERRUN
        |=> mode_reg == efbd_pkg::MODE_IDLE && $stable(count_reg))
        else $error("overrun did not return to idle with count held");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && result.event_res == efbd_pkg::EV_DONE
        |=> count_reg == 8'd0 && mode_reg == efbd_pkg::MODE_PAYLOAD)
        else $error("frame complete did not clear count");

endmodule

// File: src/escaped_frame_byte_decoder.sv
// Top level: input register, destuffing core, result register and APB register.
`timescale 1ns / 1ps

// Byte destuffing decoder: takes one received byte per clock and gives one result
// transaction per byte, held in the result register. Throughput is one byte per cycle
// and is set by the registered update of mode and byte count in the core between the input
// register and the result register; backpressure on the result side stalls the input
// only when both registers are full. Write buffer_size at address 0 only while idle.
module escaped_frame_byte_decoder
(
    input  logic                          clk,
    input  logic                          rst_n,
    efbd_rx_if.sink                       rx,
    efbd_res_if.source                    res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [efbd_pkg::PADDR_W-1:0]  paddr,
    input  logic [efbd_pkg::PDATA_W-1:0]  pwdata,
    output logic [efbd_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    logic              in_valid_reg;
    logic [7:0]        in_byte_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    efbd_pkg::result_t out_res_reg;
    efbd_pkg::result_t core_res;
    logic [7:0]        buffer_size_reg;
    logic              advance;
    logic              cfg_write;

    assign advance  = in_valid_reg && (!out_valid_reg || res.ready);
    assign rx.ready = !in_valid_reg || advance;

    efbd_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (advance),
        .rx_byte     (in_byte_reg),
        .buffer_size (buffer_size_reg),
        .result      (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    always_comb
    begin
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.event_res    = out_res_reg.event_res;
    assign res.frame_length = out_res_reg.frame_length;
    assign res.store_valid  = out_res_reg.store_valid;
    assign res.store_index  = out_res_reg.store_index;
    assign res.store_data   = out_res_reg.store_data;

    // APB register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buffer_size_reg <= efbd_pkg::BUF_SIZE_RESET;
        end
        else if (cfg_write && paddr == efbd_pkg::REG_BUFFER_SIZE)
        begin
            buffer_size_reg <= pwdata[7:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr == efbd_pkg::REG_BUFFER_SIZE)
        begin
            prdata[7:0] = buffer_size_reg;
        end
    end

endmodule

// File: test/tb_top.sv
// Self-checking testbench for the escaped frame byte decoder: frames, stalls, APB setup.
`timescale 1ns / 1ps

module tb_top;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [efbd_pkg::PADDR_W-1:0] paddr = '0;
    logic [efbd_pkg::PDATA_W-1:0] pwdata = '0;
    logic [efbd_pkg::PDATA_W-1:0] prdata;
    logic pready;

    efbd_rx_if rx_ch();
    efbd_res_if res_ch();

    escaped_frame_byte_decoder dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // decoder shadow state
    efbd_pkg::mode_t dec_mode = efbd_pkg::MODE_IDLE;
    logic [7:0]      dec_count = 8'd0;
    logic [7:0]      dec_buf_size = efbd_pkg::BUF_SIZE_RESET;

    logic [7:0]        pending_bytes[$];
    efbd_pkg::result_t expected_results[$];

    int bytes_queued = 0;
    int bytes_accepted = 0;
    int mismatches = 0;
    int frames_done = 0;
    int overruns = 0;
    int bytes_stored = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_req = 0;
    int hold_ack = 0;
    int hold_left = 0;
    logic rx_taken = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic efbd_pkg::result_t decode_rx_byte(input logic [7:0] b);
        efbd_pkg::result_t r;
        logic [7:0] d;
        r = '0;
        r.event_res = efbd_pkg::EV_NONE;
        d = b;
        if (b == efbd_pkg::CODE_DELIM)
        begin
            dec_mode = efbd_pkg::MODE_PAYLOAD;
            if (dec_count != 8'd0)
            begin
                r.event_res = efbd_pkg::EV_DONE;
                r.frame_length = dec_count;
                dec_count = 8'd0;
            end
        end
        else if (b == efbd_pkg::CODE_ESC)
        begin
            dec_mode = efbd_pkg::MODE_ESCAPE;
        end
        else if (dec_mode != efbd_pkg::MODE_IDLE)
        begin
            if (dec_mode == efbd_pkg::MODE_ESCAPE)
            begin
                dec_mode = efbd_pkg::MODE_PAYLOAD;
                d = b + efbd_pkg::ESC_OFFSET;
            end
            if (dec_count < dec_buf_size)
            begin
                r.store_valid = 1'b1;
                r.store_index = dec_count;
                r.store_data = d;
                dec_count = dec_count + 8'd1;
            end
            else
            begin
                dec_mode = efbd_pkg::MODE_IDLE;
                r.event_res = efbd_pkg::EV_OVERRUN;
                r.frame_length = dec_buf_size + 8'd1;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // result checking and prediction, sampled at the rising edge
    always @(posedge clk)
    begin : monitor
        efbd_pkg::result_t exp_r;
        if (rst_n)
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch("result transaction with no byte outstanding");
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (res_ch.event_res !== exp_r.event_res)
                        report_mismatch($sformatf("event_res got %0d want %0d",
                                                  res_ch.event_res, exp_r.event_res));
                    if (res_ch.frame_length !== exp_r.frame_length)
                        report_mismatch($sformatf("frame_length got %0d want %0d",
                                                  res_ch.frame_length, exp_r.frame_length));
                    if (res_ch.store_valid !== exp_r.store_valid)
                        report_mismatch($sformatf("store_valid got %0b want %0b",
                                                  res_ch.store_valid, exp_r.store_valid));
                    if (res_ch.store_index !== exp_r.store_index)
                        report_mismatch($sformatf("store_index got %0d want %0d",
                                                  res_ch.store_index, exp_r.store_index));
                    if (res_ch.store_data !== exp_r.store_data)
                        report_mismatch($sformatf("store_data got %02h want %02h",
                                                  res_ch.store_data, exp_r.store_data));
                    if (exp_r.event_res == efbd_pkg::EV_DONE)
                        frames_done++;
                    if (exp_r.event_res == efbd_pkg::EV_OVERRUN)
                        overruns++;
                    if (exp_r.store_valid)
                        bytes_stored++;
                end
            end
            if (rx_ch.valid && rx_ch.ready)
            begin
                expected_results.push_back(decode_rx_byte(rx_ch.rx_byte));
                bytes_accepted++;
            end
        end
        rx_taken <= rst_n && rx_ch.valid && rx_ch.ready;
    end

    // byte driver
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            rx_ch.valid <= 1'b0;
            rx_ch.rx_byte <= 8'd0;
        end
        else if (!rx_ch.valid || rx_taken)
        begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                rx_ch.valid <= 1'b1;
                rx_ch.rx_byte <= pending_bytes.pop_front();
            end
            else
            begin
                rx_ch.valid <= 1'b0;
            end
        end
    end

    // long receiver hold-off, counted here
    always @(posedge clk)
    begin
        if (hold_req != hold_ack)
        begin
            hold_ack <= hold_req;
            hold_left <= 150;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(negedge clk)
    begin
        res_ch.ready <= rst_n && (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
    end

    task automatic push_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_queued++;
    endtask

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom);
        while (b == efbd_pkg::CODE_ESC || b == efbd_pkg::CODE_DELIM)
            b = 8'($urandom);
        return b;
    endfunction

    task automatic push_frame(input int len);
        push_byte(efbd_pkg::CODE_DELIM);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(4) == 0)
            begin
                push_byte(efbd_pkg::CODE_ESC);
                if ($urandom_range(29) == 0)
                    push_byte($urandom_range(1) ? efbd_pkg::CODE_ESC : efbd_pkg::CODE_DELIM);
                else
                    push_byte(plain_byte());
            end
            else
            begin
                push_byte(plain_byte());
            end
        end
        if ($urandom_range(3) != 0)
            push_byte(efbd_pkg::CODE_DELIM);
    endtask

    task automatic wait_drained();
        while (bytes_accepted != bytes_queued || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic apb_write(input logic [7:0] val);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= efbd_pkg::REG_BUFFER_SIZE;
        pwdata <= {{(efbd_pkg::PDATA_W-8){1'b0}}, val};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        dec_buf_size = val;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic apb_check(input logic [7:0] want);
        logic [efbd_pkg::PDATA_W-1:0] got;
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= efbd_pkg::REG_BUFFER_SIZE;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        got = prdata;
        if (got !== {{(efbd_pkg::PDATA_W-8){1'b0}}, want})
            report_mismatch($sformatf("buffer_size read got %0h want %0h", got, want));
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin : stimulus
        logic [7:0] directed_a[20];
        logic [7:0] directed_b[5];
        logic [7:0] sizes[8];
        int phase_start;
        int len;
        int cap;

        directed_a = '{8'h42, 8'h7D, 8'h41, 8'h7E, 8'h00, 8'hFF, 8'h7D, 8'h5E,
                       8'h7D, 8'h5D, 8'h7D, 8'hDF, 8'h7D, 8'hE0, 8'h7D, 8'h7E,
                       8'h7D, 8'h7D, 8'h01, 8'h7E};
        directed_b = '{8'h7E, 8'h11, 8'h22, 8'h33, 8'h7E};
        sizes = '{8'd1, 8'd254, 8'd3, 8'd2, 8'd31, 8'd0, 8'd254, 8'd9};
        sizes[5] = 8'($urandom_range(254, 1));

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset value, idle bytes, escapes with wrap, escape before control bytes
        apb_check(efbd_pkg::BUF_SIZE_RESET);
        foreach (directed_a[i])
            push_byte(directed_a[i]);
        wait_drained();
        repeat (4) @(negedge clk);

        // single-byte buffer: overrun, ignored byte, delimiter after overrun
        apb_write(8'd1);
        foreach (directed_b[i])
            push_byte(directed_b[i]);

        for (int p = 0; p < 8; p++)
        begin
            wait_drained();
            repeat (4) @(negedge clk);
            apb_write(sizes[p]);
            apb_check(sizes[p]);
            case (p % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 88; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 88; end
                default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
            endcase
            if (p == 4)
                hold_req++;
            phase_start = bytes_queued;
            while (bytes_queued - phase_start < 150)
            begin
                if (p == 2 && bytes_queued - phase_start >= 75 && hold_left == 0
                    && tx_idle_pct == 0)
                begin
                    // sender pauses until the decoder has fully drained
                    wait_drained();
                    tx_idle_pct = 1;
                end
                cap = (sizes[p] > 64 && $urandom_range(5) != 0) ? 16 : sizes[p];
                case ($urandom_range(9))
                    0: len = cap + 1 + $urandom_range(2);
                    1: len = cap;
                    2: len = 0;
                    default: len = $urandom_range(cap < 16 ? cap : 16, 1);
                endcase
                if ($urandom_range(7) == 0)
                begin
                    repeat ($urandom_range(6, 1))
                        push_byte(8'($urandom));
                end
                else
                begin
                    push_frame(len);
                end
            end
        end

        wait_drained();
        repeat (10) @(negedge clk);
        if (expected_results.size() != 0)
            report_mismatch("results still outstanding at end of run");
        $display("Decoded %0d bytes: %0d frames completed, %0d overruns, %0d payload stores.",
                 bytes_accepted, frames_done, overruns, bytes_stored);
        $display("Buffer sizes 1 to 254 under free flow, sender gaps, result stalls and both.");
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// File: sim.f
src/efbd_pkg.sv
src/efbd_ifs.sv
src/efbd_core.sv
src/escaped_frame_byte_decoder.sv
test/tb_top.sv
